@@ design/ffoa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffoa_pkg
// Shared codes and field widths of the outline-area flood fill block.
// ----------------------------------------------------------------------------
package ffoa_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_FILL  = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_COLS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;

    // neighbor order around a frontier pixel
    localparam logic [2:0] NB_SELF  = 3'd0;
    localparam logic [2:0] NB_LEFT  = 3'd1;
    localparam logic [2:0] NB_RIGHT = 3'd2;
    localparam logic [2:0] NB_UP    = 3'd3;
    localparam logic [2:0] NB_DOWN  = 3'd4;

    // fixed field widths
    localparam int CNT_W = 13;
    localparam int POS_W = 6;
    localparam int DIM_W = 7;

    // mark memory entry
    typedef struct packed {
        logic outline;
        logic visited;
    } mark_t;

endpackage

@@ design/ffoa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffoa_ram
// Generic simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffoa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/flood_fill_outline_area.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flood_fill_outline_area
// Breadth-first 4-connected flood fill over a loaded binary edge image,
// reporting area and outline count, then outline points in raster order.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               contents
//  s_       in         s_tvalid / s_tready     cmd in tuser, pixel or seed in tdata
//  m_       out        m_tvalid / m_tready     counts and point in tdata, flags tuser
//  cfg_     in         cfg_valid / cfg_ready   register index and data
//
// After reset a clearing pass sweeps every entry of the mark memory; no item
// is taken meanwhile. A fill takes the same clearing pass, then for each
// frontier pixel a queue pop and its read, five neighbor reads of the pixel
// and mark memories, and a wait for the last neighbor check to land.
// A fetch scans the mark memory one entry a cycle from the scan position.
// A result waiting at the output holds the block at the end of a fill or
// fetch; no command is taken meanwhile.
// ----------------------------------------------------------------------------
module flood_fill_outline_area
    import ffoa_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: pos_x[5:0], pos_y[11:6], pixel_set[12], zero [15:13]
    input  logic [15:0] s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: area[12:0], outline_count[25:13], point_x[31:26], point_y[37:32],
    // zero [39:38]
    output logic [39:0] m_tdata,
    // tuser: point_valid[0], status[1]
    output logic [1:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    localparam int NPIX = MAX_COLS * MAX_ROWS;
    localparam int AW   = $clog2(NPIX);
    localparam int XW   = $clog2(MAX_COLS);
    localparam int YW   = $clog2(MAX_ROWS);
    localparam int CW   = $clog2(MAX_COLS + 1);
    localparam int RW   = $clog2(MAX_ROWS + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SEED  = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_QWAIT = 3'd4;
    localparam logic [2:0] S_NBR   = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    function automatic logic [AW-1:0] pix_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y);
        pix_addr = AW'(32'(y) * MAX_COLS + 32'(x));
    endfunction

    // control registers
    logic [2:0]       state_reg, state_next;
    logic [DIM_W-1:0] cols_cfg_reg, cols_cfg_next;
    logic [DIM_W-1:0] rows_cfg_reg, rows_cfg_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             clr_fill_reg, clr_fill_next;
    logic             seed_err_reg, seed_err_next;
    logic [AW:0]      head_reg, head_next;
    logic [AW:0]      tail_reg, tail_next;
    logic [2:0]       nb_k_reg, nb_k_next;
    logic             chk_v_reg, chk_v_next;
    logic [CNT_W-1:0] visit_cnt_reg, visit_cnt_next;
    logic [CNT_W-1:0] outline_cnt_reg, outline_cnt_next;
    logic [XW-1:0]    scan_x_reg, scan_x_next;
    logic [YW-1:0]    scan_y_reg, scan_y_next;
    logic             scan_end_reg, scan_end_next;
    logic             iss_end_reg, iss_end_next;
    logic             stg_v_reg, stg_v_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // payload registers
    logic [XW-1:0]    seed_x_reg, seed_x_next;
    logic [YW-1:0]    seed_y_reg, seed_y_next;
    logic [XW-1:0]    cur_x_reg, cur_x_next;
    logic [YW-1:0]    cur_y_reg, cur_y_next;
    logic [XW-1:0]    chk_x_reg, chk_x_next;
    logic [YW-1:0]    chk_y_reg, chk_y_next;
    logic [XW-1:0]    iss_x_reg, iss_x_next;
    logic [YW-1:0]    iss_y_reg, iss_y_next;
    logic [XW-1:0]    stg_x_reg, stg_x_next;
    logic [YW-1:0]    stg_y_reg, stg_y_next;
    logic [POS_W-1:0] res_px_reg, res_px_next;
    logic [POS_W-1:0] res_py_reg, res_py_next;
    logic             res_pv_reg, res_pv_next;
    logic             res_st_reg, res_st_next;
    logic [39:0]      m_tdata_reg, m_tdata_next;
    logic [1:0]       m_tuser_reg, m_tuser_next;

    // memory ports
    logic             pix_we;
    logic [AW-1:0]    pix_waddr, pix_raddr;
    logic             pix_wdata, pix_rdata;
    logic             mark_we;
    logic [AW-1:0]    mark_waddr, mark_raddr;
    mark_t            mark_wdata, mark_rdata;
    logic             q_we;
    logic [AW-1:0]    q_waddr, q_raddr;
    logic [XW+YW-1:0] q_wdata, q_rdata;

    // input fields
    logic [POS_W-1:0] in_x, in_y;
    logic             in_pix, s_fire;
    logic [CW-1:0]    cols_sat;
    logic [RW-1:0]    rows_sat;

    // neighbor and scan helpers
    logic [XW-1:0]    nb_x;
    logic [YW-1:0]    nb_y;
    logic             nb_in;
    logic [XW-1:0]    stg_inc_x;
    logic [YW-1:0]    stg_inc_y;
    logic             stg_last;
    logic [XW-1:0]    iss_inc_x;
    logic [YW-1:0]    iss_inc_y;
    logic             iss_last;

    assign in_x     = s_tdata[5:0];
    assign in_y     = s_tdata[11:6];
    assign in_pix   = s_tdata[12];
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // saturated image size
    always_comb begin
        if (cols_cfg_reg == '0) begin
            cols_sat = CW'(1);
        end else if (32'(cols_cfg_reg) > MAX_COLS) begin
            cols_sat = CW'(MAX_COLS);
        end else begin
            cols_sat = CW'(cols_cfg_reg);
        end
        if (rows_cfg_reg == '0) begin
            rows_sat = RW'(1);
        end else if (32'(rows_cfg_reg) > MAX_ROWS) begin
            rows_sat = RW'(MAX_ROWS);
        end else begin
            rows_sat = RW'(rows_cfg_reg);
        end
    end

    // neighbor coordinate and image bounds
    always_comb begin
        nb_x  = cur_x_reg;
        nb_y  = cur_y_reg;
        nb_in = 1'b1;
        unique case (nb_k_reg)
            NB_LEFT: begin
                nb_x  = XW'(cur_x_reg - 1'b1);
                nb_in = (cur_x_reg != '0);
            end
            NB_RIGHT: begin
                nb_x  = XW'(cur_x_reg + 1'b1);
                nb_in = (32'(cur_x_reg) + 1 < 32'(cols_sat));
            end
            NB_UP: begin
                nb_y  = YW'(cur_y_reg - 1'b1);
                nb_in = (cur_y_reg != '0);
            end
            NB_DOWN: begin
                nb_y  = YW'(cur_y_reg + 1'b1);
                nb_in = (32'(cur_y_reg) + 1 < 32'(rows_sat));
            end
            default: begin
                nb_in = 1'b1;
            end
        endcase
    end

    // raster successors of the scan stage and the scan issue pointer
    always_comb begin
        stg_last  = (32'(stg_x_reg) == MAX_COLS - 1) && (32'(stg_y_reg) == MAX_ROWS - 1);
        stg_inc_x = XW'(stg_x_reg + 1'b1);
        stg_inc_y = stg_y_reg;
        if (32'(stg_x_reg) == MAX_COLS - 1) begin
            stg_inc_x = '0;
            stg_inc_y = YW'(stg_y_reg + 1'b1);
        end
        iss_last  = (32'(iss_x_reg) == MAX_COLS - 1) && (32'(iss_y_reg) == MAX_ROWS - 1);
        iss_inc_x = XW'(iss_x_reg + 1'b1);
        iss_inc_y = iss_y_reg;
        if (32'(iss_x_reg) == MAX_COLS - 1) begin
            iss_inc_x = '0;
            iss_inc_y = YW'(iss_y_reg + 1'b1);
        end
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        cols_cfg_next    = cols_cfg_reg;
        rows_cfg_next    = rows_cfg_reg;
        clr_addr_next    = clr_addr_reg;
        clr_fill_next    = clr_fill_reg;
        seed_err_next    = seed_err_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        nb_k_next        = nb_k_reg;
        chk_v_next       = 1'b0;
        visit_cnt_next   = visit_cnt_reg;
        outline_cnt_next = outline_cnt_reg;
        scan_x_next      = scan_x_reg;
        scan_y_next      = scan_y_reg;
        scan_end_next    = scan_end_reg;
        iss_end_next     = iss_end_reg;
        stg_v_next       = 1'b0;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        seed_x_next      = seed_x_reg;
        seed_y_next      = seed_y_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        chk_x_next       = chk_x_reg;
        chk_y_next       = chk_y_reg;
        iss_x_next       = iss_x_reg;
        iss_y_next       = iss_y_reg;
        stg_x_next       = stg_x_reg;
        stg_y_next       = stg_y_reg;
        res_px_next      = res_px_reg;
        res_py_next      = res_py_reg;
        res_pv_next      = res_pv_reg;
        res_st_next      = res_st_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        pix_we     = 1'b0;
        pix_waddr  = pix_addr(XW'(in_x), YW'(in_y));
        pix_wdata  = in_pix;
        pix_raddr  = pix_addr(nb_x, nb_y);
        mark_we    = 1'b0;
        mark_waddr = pix_addr(chk_x_reg, chk_y_reg);
        mark_wdata = '{outline: mark_rdata.outline | pix_rdata, visited: 1'b1};
        mark_raddr = pix_addr(nb_x, nb_y);
        q_we       = 1'b0;
        q_waddr    = tail_reg[AW-1:0];
        q_wdata    = {chk_y_reg, chk_x_reg};
        q_raddr    = head_reg[AW-1:0];

        // configuration writes
        if (cfg_valid) begin
            if (cfg_index == REG_COLS) begin
                cols_cfg_next = cfg_data;
            end else if (cfg_index == REG_ROWS) begin
                rows_cfg_next = cfg_data;
            end
        end

        // check of a neighbor read issued in the previous cycle
        if (chk_v_reg) begin
            mark_we = 1'b1;
            if (!pix_rdata && !mark_rdata.visited) begin
                q_we      = 1'b1;
                tail_next = tail_reg + 1'b1;
            end
            if (pix_rdata && !mark_rdata.outline) begin
                outline_cnt_next = outline_cnt_reg + 1'b1;
            end
            if (!mark_rdata.visited) begin
                visit_cnt_next = visit_cnt_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_CLEAR: begin
                mark_we    = 1'b1;
                mark_waddr = clr_addr_reg;
                mark_wdata = '0;
                clr_addr_next = AW'(clr_addr_reg + 1'b1);
                if (clr_addr_reg == AW'(NPIX - 1)) begin
                    clr_addr_next = '0;
                    if (!clr_fill_reg) begin
                        state_next = S_IDLE;
                    end else if (seed_err_reg) begin
                        res_st_next = 1'b1;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_SEED;
                    end
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    unique case (s_tuser)
                        CMD_LOAD: begin
                            if (32'(in_x) < MAX_COLS && 32'(in_y) < MAX_ROWS) begin
                                pix_we = 1'b1;
                            end
                        end
                        CMD_FILL: begin
                            visit_cnt_next   = '0;
                            outline_cnt_next = '0;
                            scan_x_next      = '0;
                            scan_y_next      = '0;
                            scan_end_next    = 1'b0;
                            clr_fill_next    = 1'b1;
                            seed_err_next    = (32'(in_x) >= 32'(cols_sat)) ||
                                               (32'(in_y) >= 32'(rows_sat));
                            seed_x_next      = XW'(in_x);
                            seed_y_next      = YW'(in_y);
                            res_px_next      = '0;
                            res_py_next      = '0;
                            res_pv_next      = 1'b0;
                            res_st_next      = 1'b0;
                            state_next       = S_CLEAR;
                        end
                        CMD_FETCH: begin
                            res_px_next = '0;
                            res_py_next = '0;
                            res_pv_next = 1'b0;
                            res_st_next = 1'b0;
                            iss_x_next  = scan_x_reg;
                            iss_y_next  = scan_y_reg;
                            iss_end_next = 1'b0;
                            state_next  = scan_end_reg ? S_DONE : S_SCAN;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEED: begin
                mark_we        = 1'b1;
                mark_waddr     = pix_addr(seed_x_reg, seed_y_reg);
                mark_wdata     = '{outline: 1'b0, visited: 1'b1};
                q_we           = 1'b1;
                q_waddr        = '0;
                q_wdata        = {seed_y_reg, seed_x_reg};
                visit_cnt_next = CNT_W'(1);
                head_next      = '0;
                tail_next      = (AW + 1)'(1);
                state_next     = S_POP;
            end
            S_POP: begin
                if (chk_v_reg) begin
                    state_next = S_POP;
                end else if (head_reg < tail_reg) begin
                    head_next  = head_reg + 1'b1;
                    state_next = S_QWAIT;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_QWAIT: begin
                cur_x_next = q_rdata[XW-1:0];
                cur_y_next = q_rdata[XW+YW-1:XW];
                nb_k_next  = NB_SELF;
                state_next = S_NBR;
            end
            S_NBR: begin
                chk_v_next = nb_in;
                chk_x_next = nb_x;
                chk_y_next = nb_y;
                nb_k_next  = nb_k_reg + 1'b1;
                if (nb_k_reg == NB_DOWN) begin
                    state_next = S_POP;
                end
            end
            S_SCAN: begin
                mark_raddr = pix_addr(iss_x_reg, iss_y_reg);
                if (stg_v_reg && mark_rdata.outline) begin
                    res_px_next   = POS_W'(stg_x_reg);
                    res_py_next   = POS_W'(stg_y_reg);
                    res_pv_next   = 1'b1;
                    scan_x_next   = stg_inc_x;
                    scan_y_next   = stg_inc_y;
                    scan_end_next = stg_last;
                    state_next    = S_DONE;
                end else if (!iss_end_reg) begin
                    stg_v_next   = 1'b1;
                    stg_x_next   = iss_x_reg;
                    stg_y_next   = iss_y_reg;
                    iss_x_next   = iss_inc_x;
                    iss_y_next   = iss_inc_y;
                    iss_end_next = iss_last;
                end else if (!stg_v_reg) begin
                    scan_end_next = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, res_py_reg, res_px_reg,
                                     outline_cnt_reg, visit_cnt_reg};
                    m_tuser_next  = {res_st_reg, res_pv_reg};
                    clr_fill_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            cols_cfg_reg    <= DIM_W'(64);
            rows_cfg_reg    <= DIM_W'(64);
            clr_addr_reg    <= '0;
            clr_fill_reg    <= 1'b0;
            seed_err_reg    <= 1'b0;
            head_reg        <= '0;
            tail_reg        <= '0;
            nb_k_reg        <= NB_SELF;
            chk_v_reg       <= 1'b0;
            visit_cnt_reg   <= '0;
            outline_cnt_reg <= '0;
            scan_x_reg      <= '0;
            scan_y_reg      <= '0;
            scan_end_reg    <= 1'b0;
            iss_end_reg     <= 1'b0;
            stg_v_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cols_cfg_reg    <= cols_cfg_next;
            rows_cfg_reg    <= rows_cfg_next;
            clr_addr_reg    <= clr_addr_next;
            clr_fill_reg    <= clr_fill_next;
            seed_err_reg    <= seed_err_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            nb_k_reg        <= nb_k_next;
            chk_v_reg       <= chk_v_next;
            visit_cnt_reg   <= visit_cnt_next;
            outline_cnt_reg <= outline_cnt_next;
            scan_x_reg      <= scan_x_next;
            scan_y_reg      <= scan_y_next;
            scan_end_reg    <= scan_end_next;
            iss_end_reg     <= iss_end_next;
            stg_v_reg       <= stg_v_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        seed_x_reg  <= seed_x_next;
        seed_y_reg  <= seed_y_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        chk_x_reg   <= chk_x_next;
        chk_y_reg   <= chk_y_next;
        iss_x_reg   <= iss_x_next;
        iss_y_reg   <= iss_y_next;
        stg_x_reg   <= stg_x_next;
        stg_y_reg   <= stg_y_next;
        res_px_reg  <= res_px_next;
        res_py_reg  <= res_py_next;
        res_pv_reg  <= res_pv_next;
        res_st_reg  <= res_st_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // loaded edge image
    ffoa_ram #(.WIDTH(1), .DEPTH(NPIX)) u_pix_ram (
        .clk   (aclk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    // visited and outline marks
    ffoa_ram #(.WIDTH(2), .DEPTH(NPIX)) u_mark_ram (
        .clk   (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    // frontier queue of {row, column}
    ffoa_ram #(.WIDTH(XW + YW), .DEPTH(NPIX)) u_queue_ram (
        .clk   (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // the queue head never passes its tail
    a_head_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= tail_reg)
        else $error("frontier head passed tail");

    // a pending neighbor check only lives in the walk states
    a_chk_state: assert property (@(posedge aclk) disable iff (!aresetn)
        chk_v_reg |-> (state_reg == S_NBR || state_reg == S_POP))
        else $error("neighbor check outside fill walk");

    // leaving the result state always presents a result
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && (!m_tvalid_reg || m_tready)) |=> m_tvalid_reg)
        else $error("result lost at end of command");

endmodule

@@ test/flood_fill_outline_area_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flood_fill_outline_area_test
// Self-checking bench for the outline-area flood fill block. Loads, fills
// and fetches go through the input stream with random gaps. An internal fill
// predictor computes the expected counts and outline points. Results are
// compared in order, and image sizes are switched between phases.
// ----------------------------------------------------------------------------
module flood_fill_outline_area_test;
    import ffoa_pkg::*;

    localparam int NCOLS       = 64;
    localparam int NROWS       = 64;
    localparam int NPIX        = NCOLS * NROWS;
    localparam int CYCLE_CAP   = 20000000;
    localparam int TOTAL_ITEMS = 1600;

    // command and register codes with no function in the block
    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;

    typedef struct {
        logic [1:0] cmd;
        logic [5:0] x;
        logic [5:0] y;
        logic       pix;
    } fill_cmd_t;

    typedef struct {
        logic [12:0] area;
        logic [12:0] ocount;
        logic [5:0]  px;
        logic [5:0]  py;
        logic        pvalid;
        logic        status;
    } fill_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [6:0]  cfg_data = '0;

    fill_cmd_t cmd_queue[$];
    fill_res_t expected_res[$];
    fill_cmd_t cur_cmd;

    // predictor state
    logic [6:0] ref_cols_reg = 7'd64;
    logic [6:0] ref_rows_reg = 7'd64;
    logic       ref_pix[NPIX];
    logic       ref_vis[NPIX];
    logic       ref_outl[NPIX];
    int         ref_front[NPIX];
    int         ref_area;
    int         ref_ocount;
    int         ref_scan;

    int  mismatches = 0;
    int  items_sent = 0;
    int  s_gap = 0;
    int  m_gap = 0;
    bit  calm = 0;
    int  gen_cols;
    int  gen_rows;
    int  density;
    longint cycles = 0;

    flood_fill_outline_area u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic int sat_dim(logic [6:0] v, int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    // breadth-first fill and result prediction for one accepted command
    task automatic predict_cmd(fill_cmd_t c);
        int cols, rows, head, tail, p, cx, cy, nx, ny, q, k;
        int ddx[5];
        int ddy[5];
        fill_res_t r;
        ddx = '{0, -1, 1, 0, 0};
        ddy = '{0, 0, 0, -1, 1};
        r = '{default: '0};
        case (c.cmd)
            CMD_LOAD: begin
                ref_pix[c.y * NCOLS + c.x] = c.pix;
                return;
            end
            CMD_FILL: begin
                cols = sat_dim(ref_cols_reg, NCOLS);
                rows = sat_dim(ref_rows_reg, NROWS);
                for (int i = 0; i < NPIX; i++) begin
                    ref_vis[i] = 1'b0;
                    ref_outl[i] = 1'b0;
                end
                ref_area = 0;
                ref_ocount = 0;
                ref_scan = 0;
                if (c.x >= cols || c.y >= rows) begin
                    r.status = 1'b1;
                end else begin
                    head = 0;
                    tail = 0;
                    p = c.y * NCOLS + c.x;
                    ref_vis[p] = 1'b1;
                    ref_area = 1;
                    ref_front[tail++] = p;
                    while (head < tail) begin
                        p = ref_front[head++];
                        cx = p % NCOLS;
                        cy = p / NCOLS;
                        for (k = 0; k < 5; k++) begin
                            nx = cx + ddx[k];
                            ny = cy + ddy[k];
                            if (nx < 0 || ny < 0 || nx >= cols || ny >= rows) continue;
                            q = ny * NCOLS + nx;
                            if (!ref_pix[q]) begin
                                if (!ref_vis[q] && tail < NPIX) ref_front[tail++] = q;
                            end else if (!ref_outl[q]) begin
                                ref_outl[q] = 1'b1;
                                ref_ocount++;
                            end
                            if (!ref_vis[q]) begin
                                ref_vis[q] = 1'b1;
                                ref_area++;
                            end
                        end
                    end
                end
            end
            CMD_FETCH: begin
                while (ref_scan < NPIX && !ref_outl[ref_scan]) ref_scan++;
                if (ref_scan < NPIX) begin
                    r.px = 6'(ref_scan % NCOLS);
                    r.py = 6'(ref_scan / NCOLS);
                    r.pvalid = 1'b1;
                    ref_scan++;
                end
            end
            default: return;
        endcase
        r.area = 13'(ref_area);
        r.ocount = 13'(ref_ocount);
        expected_res.insert(expected_res.size(), r);
    endtask

    // input stream driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_cmd(cur_cmd);
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    cur_cmd = cmd_queue.pop_front();
                    s_tdata <= {3'b000, cur_cmd.pix, cur_cmd.y, cur_cmd.x};
                    s_tuser <= cur_cmd.cmd;
                    s_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 11) == 0) s_gap = $urandom_range(1, 17);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        fill_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.area   = m_tdata[12:0];
            got.ocount = m_tdata[25:13];
            got.px     = m_tdata[31:26];
            got.py     = m_tdata[37:32];
            got.pvalid = m_tuser[0];
            got.status = m_tuser[1];
            if (expected_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer area=%0d", got.area);
            end else begin
                want = expected_res.pop_front();
                if (got.area !== want.area || got.ocount !== want.ocount ||
                    got.px !== want.px || got.py !== want.py ||
                    got.pvalid !== want.pvalid || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp area=%0d outl=%0d pt=(%0d,%0d) v=%0d st=%0d",
                                 want.area, want.ocount, want.px, want.py, want.pvalid,
                                 want.status);
                        $display("         got area=%0d outl=%0d pt=(%0d,%0d) v=%0d st=%0d",
                                 got.area, got.ocount, got.px, got.py, got.pvalid,
                                 got.status);
                    end
                end
            end
        end
        if (m_gap > 0) begin
            m_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) m_gap = $urandom_range(1, 17);
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_cmd(logic [1:0] c, int x, int y, int p);
        fill_cmd_t f;
        f.cmd = c;
        f.x = 6'(x);
        f.y = 6'(y);
        f.pix = 1'(p);
        cmd_queue.insert(cmd_queue.size(), f);
        items_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_COLS) ref_cols_reg = val;
        else if (idx == REG_ROWS) ref_rows_reg = val;
        cfg_valid <= 1'b0;
    endtask

    // wait until every transfer is done and the block has settled
    task automatic drain();
        while (cmd_queue.size() > 0 || s_tvalid || expected_res.size() > 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic set_size(int c, int r);
        write_reg(REG_COLS, 7'(c));
        write_reg(REG_ROWS, 7'(r));
        gen_cols = sat_dim(7'(c), NCOLS);
        gen_rows = sat_dim(7'(r), NROWS);
    endtask

    // fully written region so that every fill reads known pixels
    task automatic load_region();
        for (int y = 0; y < gen_rows; y++)
            for (int x = 0; x < gen_cols; x++)
                push_cmd(CMD_LOAD, x, y, $urandom_range(0, 99) < density);
    endtask

    task automatic random_mix(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                if ($urandom_range(0, 3) != 0)
                    push_cmd(CMD_LOAD, $urandom_range(0, gen_cols - 1),
                             $urandom_range(0, gen_rows - 1), $urandom_range(0, 99) < density);
                else
                    push_cmd(CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 1));
            end else if (r < 70) begin
                // fill followed by a burst of fetches
                if ($urandom_range(0, 7) != 0)
                    push_cmd(CMD_FILL, $urandom_range(0, gen_cols - 1),
                             $urandom_range(0, gen_rows - 1), $urandom_range(0, 1));
                else
                    push_cmd(CMD_FILL, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 1));
                repeat ($urandom_range(0, 6))
                    push_cmd(CMD_FETCH, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 1));
            end else if (r < 90) begin
                push_cmd(CMD_FETCH, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1));
            end else begin
                push_cmd(CMD_SPARE, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < NPIX; i++) begin
            ref_pix[i] = 1'b0;
            ref_vis[i] = 1'b0;
            ref_outl[i] = 1'b0;
        end
        ref_area = 0;
        ref_ocount = 0;
        ref_scan = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: small 4x3 image with an edge column and one corner edge pixel
        set_size(4, 3);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 4; x++)
                push_cmd(CMD_LOAD, x, y, (x == 2) || (y == 2 && x == 3));
        push_cmd(CMD_LOAD, 63, 63, 1);
        push_cmd(CMD_FILL, 0, 0, 0);
        repeat (4) push_cmd(CMD_FETCH, 0, 0, 0);
        push_cmd(CMD_FILL, 2, 1, 1);
        push_cmd(CMD_SPARE, 63, 63, 1);
        push_cmd(CMD_FILL, 4, 0, 0);
        push_cmd(CMD_FETCH, 63, 63, 1);
        push_cmd(CMD_FILL, 3, 2, 0);
        push_cmd(CMD_FETCH, 0, 0, 0);
        drain();

        // register writes with no effect, then fetch after a size change
        write_reg(REG_SPARE_A, 7'($urandom_range(0, 127)));
        write_reg(REG_SPARE_B, 7'($urandom_range(0, 127)));
        set_size(2, 2);
        push_cmd(CMD_FETCH, 0, 0, 0);
        push_cmd(CMD_FETCH, 0, 0, 0);
        drain();

        // saturated full width, three rows
        set_size(127, 3);
        density = 25;
        load_region();
        push_cmd(CMD_FILL, 32, 1, 0);
        repeat (3) push_cmd(CMD_FETCH, 0, 0, 0);
        push_cmd(CMD_FILL, 63, 2, 0);
        push_cmd(CMD_FETCH, 0, 0, 0);
        drain();

        // width and height saturated to one, single pixel image
        set_size(0, 0);
        density = 50;
        load_region();
        push_cmd(CMD_FILL, 0, 0, 0);
        push_cmd(CMD_FETCH, 0, 0, 0);
        push_cmd(CMD_FETCH, 0, 0, 0);
        push_cmd(CMD_FILL, 1, 0, 0);
        push_cmd(CMD_FETCH, 0, 0, 0);
        drain();

        // one row, then one column
        set_size(64, 1);
        load_region();
        push_cmd(CMD_FILL, 10, 0, 0);
        repeat (3) push_cmd(CMD_FETCH, 0, 0, 0);
        drain();
        set_size(1, 64);
        load_region();
        push_cmd(CMD_FILL, 0, 40, 0);
        repeat (3) push_cmd(CMD_FETCH, 0, 0, 0);
        drain();

        // random phases, mostly small images
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= TOTAL_ITEMS - 200) calm = 1;
            if ($urandom_range(0, 9) == 0)
                set_size($urandom_range(13, 64), $urandom_range(1, 4));
            else
                set_size($urandom_range(1, 12), $urandom_range(1, 12));
            density = $urandom_range(5, 60);
            load_region();
            random_mix(100);
            drain();
        end

        drain();
        if (mismatches == 0 && expected_res.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
